>>> rtl/core/cbcs_pkg.sv
// ----------------------------------------------------------------------------
// cbcs_pkg
// Shared types and constants of the clipped box color sampler: register
// indexes, field widths, sequencer states and the window radius table.
// ----------------------------------------------------------------------------
package cbcs_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 256;
   localparam int DEFAULT_MAX_HEIGHT = 256;

   localparam int CFG_W   = 9;
   localparam int CSR_IDX_W = 2;
   localparam int COORD_W = 16;
   localparam int CHAN_W  = 8;
   localparam int NCHAN   = 4;
   localparam int CNT_W   = 7;
   localparam int SUM_W   = 15;
   localparam int REM_W   = 8;
   localparam int STEP_W  = 4;
   localparam int RAD_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_SIZE  = 2'd2;

   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_ROUND,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   function automatic logic [RAD_W-1:0] radius_of(input logic [1:0] size);
      logic [RAD_W-1:0] r;
      case (size)
         2'd0:    r = 3'd0;
         2'd1:    r = 3'd1;
         2'd2:    r = 3'd2;
         2'd3:    r = 3'd5;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/clipped_box_color_sampler_top.sv
// ----------------------------------------------------------------------------
// clipped_box_color_sampler_top
// RGBA frame store with point and clipped box-window sampling.
//
//   channel   direction   handshake             beat
//   req_      in          req_valid/req_stall   one pixel write or one sample
//   rsp_      out         rsp_valid/rsp_stall   one color per sample
//   csr_      in          csr_write_enable      one register write
//
// A pixel write is stored as its beat is taken. A sample reads its n clipped-window
// pixels from the frame store one per cycle over its single read port, then
// rounds and divides in a one-bit-per-step divider. An off-image sample skips
// the read and the divide. One item is in work at a time; the
// next item is taken while a result waits in the output register.
// Reset is synchronous and clears control and registers, not the frame store.
// ----------------------------------------------------------------------------
module clipped_box_color_sampler_top #(
   parameter int MAX_WIDTH  = cbcs_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = cbcs_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_action,
   input  logic signed [cbcs_pkg::COORD_W-1:0]    req_x,
   input  logic signed [cbcs_pkg::COORD_W-1:0]    req_y,
   input  logic        [cbcs_pkg::CHAN_W-1:0]     req_red_in,
   input  logic        [cbcs_pkg::CHAN_W-1:0]     req_green_in,
   input  logic        [cbcs_pkg::CHAN_W-1:0]     req_blue_in,
   input  logic        [cbcs_pkg::CHAN_W-1:0]     req_alpha_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_found,
   output logic        [cbcs_pkg::CHAN_W-1:0]     rsp_red_out,
   output logic        [cbcs_pkg::CHAN_W-1:0]     rsp_green_out,
   output logic        [cbcs_pkg::CHAN_W-1:0]     rsp_blue_out,
   output logic        [cbcs_pkg::CHAN_W-1:0]     rsp_alpha_out,
   input  logic                                   csr_write_enable,
   input  logic        [cbcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [cbcs_pkg::CFG_W-1:0]      csr_data
);

   localparam int CW    = cbcs_pkg::CFG_W;
   localparam int CH    = cbcs_pkg::CHAN_W;
   localparam int NC    = cbcs_pkg::NCHAN;
   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

   // configuration
   logic [CW-1:0] width_ff, height_ff;
   logic [1:0]    size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         size_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            cbcs_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            cbcs_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            cbcs_pkg::CSR_SAMPLE_SIZE:  size_ff   <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0] eff_w, eff_h;
   assign eff_w = (int'(width_ff)  > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : width_ff;
   assign eff_h = (int'(height_ff) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : height_ff;

   // input beat decode
   logic                  req_accept;
   logic                  on_image;
   logic [CW-1:0]         cx, cy;
   logic [cbcs_pkg::RAD_W-1:0] radius;
   logic [CW-1:0]         rad9;
   logic [CW:0]           cx_hi, cy_hi;
   logic [CW-1:0]         x0, y0, x1, y1;
   logic [CW-1:0]         w_last, h_last;
   logic [AW-1:0]         wr_addr;
   logic                  wr_en;

   assign req_accept = req_valid && !req_stall;
   assign cx = req_x[CW-1:0];
   assign cy = req_y[CW-1:0];
   assign on_image = (eff_w != '0) && (eff_h != '0) && !req_x[15] && !req_y[15]
                     && (req_x[14:0] < 15'(eff_w)) && (req_y[14:0] < 15'(eff_h));
   assign radius = cbcs_pkg::radius_of(size_ff);
   assign rad9   = CW'(radius);
   assign w_last = eff_w - 1'b1;
   assign h_last = eff_h - 1'b1;
   assign cx_hi  = {1'b0, cx} + {1'b0, rad9};
   assign cy_hi  = {1'b0, cy} + {1'b0, rad9};
   assign x0 = (cx < rad9) ? '0 : cx - rad9;
   assign y0 = (cy < rad9) ? '0 : cy - rad9;
   assign x1 = (cx_hi > {1'b0, w_last}) ? w_last : cx_hi[CW-1:0];
   assign y1 = (cy_hi > {1'b0, h_last}) ? h_last : cy_hi[CW-1:0];
   assign wr_addr = AW'(cy) * ROW_STEP + AW'(cx);
   assign wr_en = req_accept && (req_action == cbcs_pkg::ACTION_WRITE) && on_image;

   // sequencer
   cbcs_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  x0_ff, x1_ff, y1_ff, xc_ff, yc_ff;
   logic [AW-1:0]  row_base_ff, rd_addr;
   logic           sweep_last;
   logic [cbcs_pkg::STEP_W-1:0] step_ff;
   logic           rsp_valid_ff;
   logic           rsp_load;

   assign rd_addr    = row_base_ff + AW'(xc_ff);
   assign sweep_last = (xc_ff == x1_ff) && (yc_ff == y1_ff);
   assign req_stall  = (state_ff != cbcs_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbcs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      case (state_ff)
         cbcs_pkg::ST_IDLE: begin
            if (req_accept && (req_action == cbcs_pkg::ACTION_SAMPLE)) begin
               state_in = on_image ? cbcs_pkg::ST_SWEEP : cbcs_pkg::ST_FINISH;
            end
         end
         cbcs_pkg::ST_SWEEP: begin
            if (sweep_last) begin
               state_in = cbcs_pkg::ST_DRAIN;
            end
         end
         cbcs_pkg::ST_DRAIN: state_in = cbcs_pkg::ST_ROUND;
         cbcs_pkg::ST_ROUND: state_in = cbcs_pkg::ST_DIVIDE;
         cbcs_pkg::ST_DIVIDE: begin
            if (step_ff == cbcs_pkg::STEP_W'(cbcs_pkg::SUM_W - 1)) begin
               state_in = cbcs_pkg::ST_FINISH;
            end
         end
         cbcs_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = cbcs_pkg::ST_IDLE;
            end
         end
         default: state_in = cbcs_pkg::ST_IDLE;
      endcase
   end

   // frame store
   logic [NC*CH-1:0] frame_mem [CELLS];
   logic [NC*CH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= {req_alpha_in, req_blue_in, req_green_in, req_red_in};
      end
      if (state_ff == cbcs_pkg::ST_SWEEP) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= (state_ff == cbcs_pkg::ST_SWEEP);
      end
   end

   // accumulate and divide
   logic [cbcs_pkg::CNT_W-1:0] count_ff;
   logic                       found_ff;
   logic [cbcs_pkg::SUM_W-1:0] sum_ff [NC];
   logic [cbcs_pkg::SUM_W-1:0] dvd_ff [NC];
   logic [cbcs_pkg::REM_W-1:0] rem_ff [NC];
   logic [cbcs_pkg::SUM_W-1:0] dvd_in [NC];
   logic [cbcs_pkg::REM_W-1:0] rem_in [NC];

   always_comb begin
      logic [cbcs_pkg::REM_W-1:0] rem_sh;
      logic [cbcs_pkg::REM_W-1:0] divisor;
      divisor = cbcs_pkg::REM_W'(count_ff);
      for (int c = 0; c < NC; c++) begin
         rem_sh = {rem_ff[c][cbcs_pkg::REM_W-2:0], dvd_ff[c][cbcs_pkg::SUM_W-1]};
         if (rem_sh >= divisor) begin
            rem_in[c] = rem_sh - divisor;
            dvd_in[c] = {dvd_ff[c][cbcs_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in[c] = rem_sh;
            dvd_in[c] = {dvd_ff[c][cbcs_pkg::SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         cbcs_pkg::ST_IDLE: begin
            if (req_accept && (req_action == cbcs_pkg::ACTION_SAMPLE)) begin
               found_ff    <= on_image;
               x0_ff       <= x0;
               x1_ff       <= x1;
               y1_ff       <= y1;
               xc_ff       <= x0;
               yc_ff       <= y0;
               row_base_ff <= AW'(y0) * ROW_STEP;
               count_ff    <= '0;
               for (int c = 0; c < NC; c++) begin
                  sum_ff[c] <= '0;
                  dvd_ff[c] <= '0;
               end
            end
         end
         cbcs_pkg::ST_SWEEP: begin
            count_ff <= count_ff + 1'b1;
            if (xc_ff == x1_ff) begin
               xc_ff       <= x0_ff;
               yc_ff       <= yc_ff + 1'b1;
               row_base_ff <= row_base_ff + ROW_STEP;
            end else begin
               xc_ff <= xc_ff + 1'b1;
            end
         end
         cbcs_pkg::ST_ROUND: begin
            step_ff <= '0;
            for (int c = 0; c < NC; c++) begin
               dvd_ff[c] <= sum_ff[c] + cbcs_pkg::SUM_W'(count_ff >> 1);
               rem_ff[c] <= '0;
            end
         end
         cbcs_pkg::ST_DIVIDE: begin
            step_ff <= step_ff + 1'b1;
            for (int c = 0; c < NC; c++) begin
               dvd_ff[c] <= dvd_in[c];
               rem_ff[c] <= rem_in[c];
            end
         end
         default: ;
      endcase
      if (rd_valid_ff) begin
         for (int c = 0; c < NC; c++) begin
            sum_ff[c] <= sum_ff[c] + cbcs_pkg::SUM_W'(rd_data_ff[c*CH +: CH]);
         end
      end
   end

   // output register
   logic          found_out_ff;
   logic [CH-1:0] color_ff [NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         found_out_ff <= found_ff;
         for (int c = 0; c < NC; c++) begin
            color_ff[c] <= dvd_ff[c][CH-1:0];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = found_out_ff;
   assign rsp_red_out   = color_ff[0];
   assign rsp_green_out = color_ff[1];
   assign rsp_blue_out  = color_ff[2];
   assign rsp_alpha_out = color_ff[3];

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clipped box color sampler. A behavioral mirror
// of the frame store and registers predicts every sampled color; each rsp
// beat is checked field by field against the oldest prediction. Directed
// tests cover empty and oversized images, clipped windows, rounding and
// writes that fall off the image. Random traffic follows under three
// idle/stall mixes. Before any window is sampled, every pixel in it is
// written first, so no unwritten location is ever read.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W        = cbcs_pkg::DEFAULT_MAX_WIDTH;
   localparam int MAX_H        = cbcs_pkg::DEFAULT_MAX_HEIGHT;
   localparam int DRAIN_CYCLES = 160;
   localparam int REPORT_LIMIT = 10;
   localparam logic [cbcs_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic                        found;
      logic [cbcs_pkg::CHAN_W-1:0] red;
      logic [cbcs_pkg::CHAN_W-1:0] green;
      logic [cbcs_pkg::CHAN_W-1:0] blue;
      logic [cbcs_pkg::CHAN_W-1:0] alpha;
   } color_type;

   logic                                  clock            = 1'b0;
   logic                                  reset            = 1'b1;
   logic                                  req_valid        = 1'b0;
   logic                                  req_stall;
   logic                                  req_action       = cbcs_pkg::ACTION_WRITE;
   logic signed [cbcs_pkg::COORD_W-1:0]   req_x            = '0;
   logic signed [cbcs_pkg::COORD_W-1:0]   req_y            = '0;
   logic        [cbcs_pkg::CHAN_W-1:0]    req_red_in       = '0;
   logic        [cbcs_pkg::CHAN_W-1:0]    req_green_in     = '0;
   logic        [cbcs_pkg::CHAN_W-1:0]    req_blue_in      = '0;
   logic        [cbcs_pkg::CHAN_W-1:0]    req_alpha_in     = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall        = 1'b0;
   logic                                  rsp_found;
   logic        [cbcs_pkg::CHAN_W-1:0]    rsp_red_out;
   logic        [cbcs_pkg::CHAN_W-1:0]    rsp_green_out;
   logic        [cbcs_pkg::CHAN_W-1:0]    rsp_blue_out;
   logic        [cbcs_pkg::CHAN_W-1:0]    rsp_alpha_out;
   logic                                  csr_write_enable = 1'b0;
   logic        [cbcs_pkg::CSR_IDX_W-1:0] csr_index        = cbcs_pkg::CSR_IMAGE_WIDTH;
   logic        [cbcs_pkg::CFG_W-1:0]     csr_data         = '0;

   // mirror of the block
   logic [31:0]  frame_mirror  [0:MAX_W*MAX_H-1];
   bit           pixel_written [0:MAX_W*MAX_H-1];
   logic [cbcs_pkg::CFG_W-1:0] img_width  = '0;
   logic [cbcs_pkg::CFG_W-1:0] img_height = '0;
   logic [1:0]                 img_size   = '0;

   color_type expected_colors[$];

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hot_x        = 0;
   int hot_y        = 0;
   int busy_items   = 0;
   int samples_sent = 0;
   int samples_seen = 0;
   int pixel_writes = 0;
   int reg_writes   = 0;
   int mismatches   = 0;

   clipped_box_color_sampler_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_x            (req_x),
      .req_y            (req_y),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_alpha_in     (req_alpha_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_alpha_out    (rsp_alpha_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   function automatic int eff_width();
      return (img_width > MAX_W) ? MAX_W : int'(img_width);
   endfunction

   function automatic int eff_height();
      return (img_height > MAX_H) ? MAX_H : int'(img_height);
   endfunction

   function automatic int window_radius();
      int r;
      case (img_size)
         2'd0:    r = 0;
         2'd1:    r = 1;
         2'd2:    r = 2;
         default: r = 5;
      endcase
      return r;
   endfunction

   function automatic bit pixel_on_image(int x, int y);
      return eff_width() > 0 && eff_height() > 0 && x >= 0 && y >= 0 &&
             x < eff_width() && y < eff_height();
   endfunction

   function automatic color_type average_window(int cx, int cy);
      color_type   c;
      int          r, x0, x1, y0, y1;
      int unsigned sum [4];
      int unsigned n;
      logic [31:0] p;
      c = '0;
      if (!pixel_on_image(cx, cy)) return c;
      r  = window_radius();
      x0 = (cx - r < 0) ? 0 : cx - r;
      y0 = (cy - r < 0) ? 0 : cy - r;
      x1 = (cx + r > eff_width() - 1) ? eff_width() - 1 : cx + r;
      y1 = (cy + r > eff_height() - 1) ? eff_height() - 1 : cy + r;
      sum = '{0, 0, 0, 0};
      n = 0;
      for (int y = y0; y <= y1; y++) begin
         for (int x = x0; x <= x1; x++) begin
            p = frame_mirror[y * MAX_W + x];
            for (int k = 0; k < 4; k++) sum[k] += p[8*k +: 8];
            n++;
         end
      end
      c.found = 1'b1;
      c.red   = cbcs_pkg::CHAN_W'((sum[0] + n / 2) / n);
      c.green = cbcs_pkg::CHAN_W'((sum[1] + n / 2) / n);
      c.blue  = cbcs_pkg::CHAN_W'((sum[2] + n / 2) / n);
      c.alpha = cbcs_pkg::CHAN_W'((sum[3] + n / 2) / n);
      return c;
   endfunction

   function automatic logic [31:0] random_rgba();
      logic [31:0] v;
      case ($urandom_range(7))
         0:       v = 32'h0000_0000;
         1:       v = 32'hFFFF_FFFF;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic int any_coord();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   // mostly near a hot spot so written pixels get reused, some edges and noise
   function automatic int pick_coord(int extent, int hot);
      int v;
      case ($urandom_range(9))
         0: v = any_coord();
         1: v = $urandom_range(1) ? extent : -1;
         2: v = $urandom_range(1) ? extent - 1 : 0;
         default: begin
            v = hot + int'($urandom_range(24)) - 12;
            if (v > extent - 1) v = extent - 1;
            if (v < 0) v = 0;
         end
      endcase
      return v;
   endfunction

   function automatic int pick_extent();
      int v;
      case ($urandom_range(9))
         0:       v = 0;
         1:       v = 1;
         6:       v = MAX_W;
         7:       v = $urandom_range(MAX_W + 1, 511);
         8:       v = 511;
         9:       v = $urandom_range(17, MAX_W - 1);
         default: v = $urandom_range(2, 16);
      endcase
      return v;
   endfunction

   task automatic send_item(logic action, int x, int y, logic [31:0] rgba);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= action;
      req_x        <= cbcs_pkg::COORD_W'(x);
      req_y        <= cbcs_pkg::COORD_W'(y);
      req_red_in   <= rgba[7:0];
      req_green_in <= rgba[15:8];
      req_blue_in  <= rgba[23:16];
      req_alpha_in <= rgba[31:24];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (action == cbcs_pkg::ACTION_SAMPLE) begin
         expected_colors.push_back(average_window(x, y));
         samples_sent++;
      end else if (pixel_on_image(x, y)) begin
         frame_mirror[y * MAX_W + x]  = rgba;
         pixel_written[y * MAX_W + x] = 1'b1;
         pixel_writes++;
      end
      busy_items++;
   endtask

   task automatic write_pixel(int x, int y, logic [31:0] rgba);
      send_item(cbcs_pkg::ACTION_WRITE, x, y, rgba);
   endtask

   // fills any unwritten pixel of the window before the sample beat
   task automatic sample_at(int x, int y);
      int r, x0, x1, y0, y1;
      if (pixel_on_image(x, y)) begin
         r  = window_radius();
         x0 = (x - r < 0) ? 0 : x - r;
         y0 = (y - r < 0) ? 0 : y - r;
         x1 = (x + r > eff_width() - 1) ? eff_width() - 1 : x + r;
         y1 = (y + r > eff_height() - 1) ? eff_height() - 1 : y + r;
         for (int j = y0; j <= y1; j++) begin
            for (int i = x0; i <= x1; i++) begin
               if (!pixel_written[j * MAX_W + i]) write_pixel(i, j, random_rgba());
            end
         end
      end
      send_item(cbcs_pkg::ACTION_SAMPLE, x, y, random_rgba());
   endtask

   task automatic csr_write(logic [cbcs_pkg::CSR_IDX_W-1:0] idx,
                            logic [cbcs_pkg::CFG_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      case (idx)
         cbcs_pkg::CSR_IMAGE_WIDTH:  img_width  = data;
         cbcs_pkg::CSR_IMAGE_HEIGHT: img_height = data;
         cbcs_pkg::CSR_SAMPLE_SIZE:  img_size   = data[1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic note_mismatch(string what, color_type want, color_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t: %s exp found=%0b rgba=%02h %02h %02h %02h",
                  $realtime, what, want.found, want.red, want.green, want.blue, want.alpha);
         $display("   got found=%0b rgba=%02h %02h %02h %02h",
                  got.found, got.red, got.green, got.blue, got.alpha);
      end
   endtask

   always @(posedge clock) begin : check_colors
      color_type want;
      color_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_found, rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out};
         samples_seen++;
         if (expected_colors.size() == 0) begin
            note_mismatch("unexpected beat", '0, got);
         end else begin
            want = expected_colors.pop_front();
            if (got.found !== want.found || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue ||
                got.alpha !== want.alpha) begin
               note_mismatch("color mismatch", want, got);
            end
         end
      end
   end

   task automatic test_empty_image();
      sample_at(0, 0);
      write_pixel(0, 0, 32'h1234_5678);
      wait_idle();
   endtask

   task automatic test_small_image_windows();
      csr_write(cbcs_pkg::CSR_IMAGE_WIDTH, 9'd3);
      csr_write(cbcs_pkg::CSR_IMAGE_HEIGHT, 9'd2);
      csr_write(cbcs_pkg::CSR_SAMPLE_SIZE, 9'd0);
      write_pixel(0, 0, 32'h0000_0000);
      write_pixel(1, 0, 32'hFFFF_FFFF);
      write_pixel(2, 0, 32'h80FF_017F);
      write_pixel(0, 1, 32'hFFFF_FFFF);
      write_pixel(1, 1, 32'h0000_0000);
      write_pixel(2, 1, random_rgba());
      sample_at(2, 1);
      sample_at(0, 0);
      sample_at(3, 0);
      sample_at(0, 2);
      sample_at(-1, 0);
      sample_at(-32768, 32767);
      sample_at(32767, -32768);
      wait_idle();
      csr_write(cbcs_pkg::CSR_SAMPLE_SIZE, 9'd1);
      sample_at(0, 0);
      sample_at(2, 1);
      wait_idle();
      csr_write(cbcs_pkg::CSR_SAMPLE_SIZE, 9'd3);
      sample_at(1, 1);
      wait_idle();
   endtask

   // a write outside a narrowed image must leave the old pixel intact
   task automatic test_write_off_image();
      csr_write(cbcs_pkg::CSR_IMAGE_WIDTH, 9'd2);
      csr_write(cbcs_pkg::CSR_SAMPLE_SIZE, 9'd0);
      write_pixel(2, 0, 32'hFFFF_FFFF);
      write_pixel(0, -1, 32'hFFFF_FFFF);
      wait_idle();
      csr_write(cbcs_pkg::CSR_IMAGE_WIDTH, 9'd3);
      sample_at(2, 0);
      wait_idle();
   endtask

   task automatic test_oversized_image();
      csr_write(cbcs_pkg::CSR_IMAGE_WIDTH, 9'h1FF);
      csr_write(cbcs_pkg::CSR_IMAGE_HEIGHT, 9'd257);
      csr_write(cbcs_pkg::CSR_SAMPLE_SIZE, 9'd1);
      sample_at(255, 255);
      sample_at(256, 0);
      sample_at(0, 256);
      wait_idle();
      csr_write(CSR_UNUSED, 9'h1FF);
      sample_at(255, 255);
      wait_idle();
   endtask

   task automatic random_config();
      csr_write(cbcs_pkg::CSR_IMAGE_WIDTH, cbcs_pkg::CFG_W'(pick_extent()));
      csr_write(cbcs_pkg::CSR_IMAGE_HEIGHT, cbcs_pkg::CFG_W'(pick_extent()));
      csr_write(cbcs_pkg::CSR_SAMPLE_SIZE, {7'($urandom), 2'($urandom_range(3))});
      if ($urandom_range(3) == 0) csr_write(CSR_UNUSED, cbcs_pkg::CFG_W'($urandom));
      hot_x = (eff_width() > 0) ? $urandom_range(eff_width() - 1) : 0;
      hot_y = (eff_height() > 0) ? $urandom_range(eff_height() - 1) : 0;
   endtask

   task automatic test_random_traffic(int target);
      int start;
      int chunk;
      int roll;
      start = busy_items;
      while (busy_items - start < target) begin
         random_config();
         chunk = $urandom_range(30, 80);
         for (int k = 0; k < chunk; k++) begin
            roll = $urandom_range(99);
            if (roll < 50)
               sample_at(pick_coord(eff_width(), hot_x), pick_coord(eff_height(), hot_y));
            else if (roll < 85)
               write_pixel(pick_coord(eff_width(), hot_x), pick_coord(eff_height(), hot_y),
                           random_rgba());
            else if (roll < 93)
               write_pixel(any_coord(), any_coord(), random_rgba());
            else
               sample_at(any_coord(), any_coord());
         end
         wait_idle();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 29;
      rsp_idle_pct = 72;
      test_empty_image();
      test_small_image_windows();
      test_write_off_image();
      test_oversized_image();
      test_random_traffic(530);

      req_idle_pct = 72;
      rsp_idle_pct = 29;
      test_random_traffic(530);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_traffic(540);

      wait_idle();
      $display("run covered %0d samples (%0d beats seen), %0d pixel writes, %0d register writes",
               samples_sent, samples_seen, pixel_writes, reg_writes);
      $display("idle mixes: sender 29/receiver 72, sender 72/receiver 29, none; %0d mismatches",
               mismatches);
      if (mismatches == 0 && expected_colors.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/cbcs_pkg.sv
rtl/core/clipped_box_color_sampler_top.sv
verif/tb_top.sv
